// File: src/rycc_pkg.sv
// Shared types and fixed-point constants for the RGB to YCbCr converter.
// No dependencies; used by rycc_convert and rgb_to_ycbcr_convert_core.
`default_nettype none

package rycc_pkg;

   localparam int PIX_W     = 8;
   localparam int FRAC_BITS = 16;
   // 8-bit pixel times 17-bit coefficient, three terms plus offset, plus sign
   localparam int ACC_W     = 27;

   typedef logic signed [ACC_W-1:0] acc_type;

   // Coefficients in signed Q.16
   localparam acc_type KY_R  = acc_type'(19595);
   localparam acc_type KY_G  = acc_type'(38470);
   localparam acc_type KY_B  = acc_type'(7471);
   localparam acc_type KCB_R = -acc_type'(11049);
   localparam acc_type KCB_G = -acc_type'(21699);
   localparam acc_type KCB_B = acc_type'(32748);
   localparam acc_type KCR_R = acc_type'(32755);
   localparam acc_type KCR_G = -acc_type'(27427);
   localparam acc_type KCR_B = -acc_type'(5328);

   localparam acc_type ROUND_HALF    = acc_type'(1) <<< (FRAC_BITS - 1);
   localparam acc_type CHROMA_OFFSET = acc_type'(128) <<< FRAC_BITS;

   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
   } rgb_type;

   typedef struct packed {
      logic [PIX_W-1:0] luma;
      logic [PIX_W-1:0] chroma_blue;
      logic [PIX_W-1:0] chroma_red;
   } ycc_type;

endpackage

`default_nettype wire

// File: src/rycc_convert.sv
// Combinational color matrix: three constant multiply-accumulates,
// round half up and clamp to 0..255. Depends on rycc_pkg.
`default_nettype none

module rycc_convert (
   input  wire rycc_pkg::rgb_type pix_rgb,
   output rycc_pkg::ycc_type      pix_ycc
);

   function automatic logic [rycc_pkg::PIX_W-1:0] round_clamp(input rycc_pkg::acc_type acc);
      logic [rycc_pkg::PIX_W-1:0] res;
      if (acc[rycc_pkg::ACC_W-1]) begin
         res = '0;
      end else if (|acc[rycc_pkg::ACC_W-2:rycc_pkg::FRAC_BITS+rycc_pkg::PIX_W]) begin
         res = '1;
      end else begin
         res = acc[rycc_pkg::FRAC_BITS+rycc_pkg::PIX_W-1:rycc_pkg::FRAC_BITS];
      end
      return res;
   endfunction

   rycc_pkg::acc_type r_ext;
   rycc_pkg::acc_type g_ext;
   rycc_pkg::acc_type b_ext;
   rycc_pkg::acc_type y_acc;
   rycc_pkg::acc_type cb_acc;
   rycc_pkg::acc_type cr_acc;

   localparam int PAD_W = rycc_pkg::ACC_W - rycc_pkg::PIX_W;

   assign r_ext = rycc_pkg::acc_type'({{PAD_W{1'b0}}, pix_rgb.red});
   assign g_ext = rycc_pkg::acc_type'({{PAD_W{1'b0}}, pix_rgb.green});
   assign b_ext = rycc_pkg::acc_type'({{PAD_W{1'b0}}, pix_rgb.blue});

   // Rounding half is folded into each sum
   assign y_acc  = r_ext * rycc_pkg::KY_R + g_ext * rycc_pkg::KY_G
                 + b_ext * rycc_pkg::KY_B + rycc_pkg::ROUND_HALF;
   assign cb_acc = r_ext * rycc_pkg::KCB_R + g_ext * rycc_pkg::KCB_G
                 + b_ext * rycc_pkg::KCB_B + rycc_pkg::CHROMA_OFFSET + rycc_pkg::ROUND_HALF;
   assign cr_acc = r_ext * rycc_pkg::KCR_R + g_ext * rycc_pkg::KCR_G
                 + b_ext * rycc_pkg::KCR_B + rycc_pkg::CHROMA_OFFSET + rycc_pkg::ROUND_HALF;

   assign pix_ycc.luma        = round_clamp(y_acc);
   assign pix_ycc.chroma_blue = round_clamp(cb_acc);
   assign pix_ycc.chroma_red  = round_clamp(cr_acc);

endmodule

`default_nettype wire

// File: src/rgb_to_ycbcr_convert_core.sv
// RGB to YCbCr (BT.601 coefficients) converter, one pixel per request.
// Input reg, then result reg; the result register frees each cycle it is taken.
// Throughput: 1 request per cycle while rsp_stall is low.
// Reset: synchronous, active high; clears both valid flags, payload regs not reset.
// Depends on rycc_pkg and rycc_convert.
`default_nettype none

module rgb_to_ycbcr_convert_core (
   input  wire        clock,
   input  wire        reset,
   // request channel
   input  wire        req_valid,
   output logic       req_stall,
   input  wire  [7:0] req_red,
   input  wire  [7:0] req_green,
   input  wire  [7:0] req_blue,
   // result channel
   output logic       rsp_valid,
   input  wire        rsp_stall,
   output logic [7:0] rsp_luma,
   output logic [7:0] rsp_chroma_blue,
   output logic [7:0] rsp_chroma_red
);

   // Input stage: holds the accepted request pixel
   logic              in_valid_ff;
   logic              in_valid_in;
   rycc_pkg::rgb_type in_pix_ff;
   rycc_pkg::rgb_type in_pix_in;

   // Result stage
   logic              out_valid_ff;
   logic              out_valid_in;
   rycc_pkg::ycc_type out_pix_ff;
   rycc_pkg::ycc_type out_pix_in;
   rycc_pkg::ycc_type conv_pix;

   logic out_load;   // result register takes the input stage this cycle
   logic req_take;   // request accepted this cycle

   // Result register is free when empty or being drained this cycle
   assign out_load  = in_valid_ff && (!out_valid_ff || !rsp_stall);
   // Input stage can take a new pixel when empty or moving forward
   assign req_stall = in_valid_ff && !out_load;
   assign req_take  = req_valid && !req_stall;

   rycc_convert u_convert (
      .pix_rgb (in_pix_ff),
      .pix_ycc (conv_pix)
   );

   always_comb begin
      in_valid_in = req_take || (in_valid_ff && !out_load);
      in_pix_in   = in_pix_ff;
      if (req_take) begin
         in_pix_in.red   = req_red;
         in_pix_in.green = req_green;
         in_pix_in.blue  = req_blue;
      end

      out_valid_in = out_load || (out_valid_ff && rsp_stall);
      out_pix_in   = out_load ? conv_pix : out_pix_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_pix_ff  <= in_pix_in;
      out_pix_ff <= out_pix_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_luma        = out_pix_ff.luma;
   assign rsp_chroma_blue = out_pix_ff.chroma_blue;
   assign rsp_chroma_red  = out_pix_ff.chroma_red;

`ifndef NO_ASSERTIONS
   // A pixel moved into the result stage shows up as a valid result next cycle
   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      out_load |=> out_valid_ff)
      else $error("result stage lost a loaded pixel");

   // The loaded result equals the conversion of the pixel held at load time
   a_load_data: assert property (@(posedge clock) disable iff (reset)
      out_load |=> (out_pix_ff == $past(conv_pix)))
      else $error("result stage data does not match conversion");

   // Requests are only stalled while the input stage holds a pixel
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("request stalled with empty input stage");

   // Result taken and nothing behind it leaves the result stage empty
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_stall && !in_valid_ff) |=> !out_valid_ff)
      else $error("result repeated after being taken");
`endif

endmodule

`default_nettype wire
